// ----- hw/rtl/htb_pkg.sv -----
package htb_pkg;

    localparam int MAX_SYMBOLS = 512;
    localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS;
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int NODE_W      = 11;
    localparam int CNT_W       = 10;
    localparam int FREQ_W      = 32;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_W       = 10;

    localparam logic [NODE_W-1:0] NO_NODE = 11'h7FF;

    typedef enum logic [1:0] {
        ST_SYMBOL  = 2'd0,
        ST_BUILT   = 2'd1,
        ST_MISSING = 2'd2,
        ST_NO_TREE = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYMBOL_COUNT = 4'd0,
        REG_GREEDY_MODE  = 4'd1
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_PICK,
        S_SCAN,
        S_MARK,
        S_PARENT,
        S_DONE,
        S_NOTREE,
        S_WALK
    } state_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              valid;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
    } node_t;

    typedef struct packed {
        logic    load;
        logic    walk_read;
        logic    sweep_step;
        logic    pick_init;
        logic    scan_step;
        logic    mark;
        logic    parent;
        logic    walk_eval;
        logic    finish;
        logic    emit;
        status_t emit_code;
    } cmd_t;

    typedef struct packed {
        logic    build_start;
        logic    tree_ready;
        logic    sweep_done;
        logic    scan_done;
        logic    j_is_one;
        logic    build_stop;
        logic    walk_result;
        status_t walk_code;
        logic    slot_free;
    } stat_t;

endpackage

// ----- hw/rtl/htb_in_if.sv -----
interface htb_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] table_byte;
    logic       code_bit;

    modport source (output valid, kind, table_byte, code_bit, input ready);
    modport sink (input valid, kind, table_byte, code_bit, output ready);
endinterface

// ----- hw/rtl/htb_out_if.sv -----
interface htb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [8:0]  symbol;
    logic [10:0] node_count;

    modport source (output valid, status, symbol, node_count, input ready);
    modport sink (input valid, status, symbol, node_count, output ready);
endinterface

// ----- hw/rtl/htb_datapath.sv -----
module htb_datapath
    import htb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [7:0]           table_byte,
    input  logic                 code_bit,
    input  cmd_t                 cmd,
    output stat_t                stat,
    htb_out_if.source            out_ch
);

    node_t mem [NODE_DEPTH];
    node_t rd_q;
    logic               rd_en;
    logic [NODE_AW-1:0] rd_addr;
    logic               wr_en;
    logic [NODE_AW-1:0] wr_addr;
    node_t              wr_data;

    logic [CNT_W-1:0]  symbol_count_reg;
    logic              greedy_reg;
    logic [FREQ_W-1:0] acc_reg, acc_next;
    logic [5:0]        shift_reg, shift_next;
    logic [CNT_W-1:0]  loaded_reg;
    logic [FREQ_W-1:0] freq_total_reg;
    logic              tree_ready_reg;
    logic [NODE_W-1:0] nodes_reg;
    logic [NODE_W-1:0] walk_reg;
    logic [CNT_W-1:0]  leaf_count_reg;
    logic [CNT_W-1:0]  eff_n_reg;
    logic [NODE_W-1:0] total_reg;
    logic [CNT_W-1:0]  iter_reg;
    logic [NODE_W-1:0] k_reg;
    logic [NODE_W-1:0] kq_reg;
    logic              p_reg;
    logic              seeded_reg;
    logic [FREQ_W-1:0] minv_reg;
    logic [NODE_W-1:0] best_reg;
    node_t             best_rec_reg;
    logic              j_reg;
    logic [NODE_W-1:0] ch0_reg;
    logic [FREQ_W-1:0] sum_reg;
    logic              bit_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [8:0]        out_symbol_reg;
    logic [NODE_W-1:0] out_count_reg;

    logic [CNT_W-1:0]  n_eff;
    logic [38:0]       shifted;
    logic              is_end;
    logic              store;
    logic [CNT_W-1:0]  lc_after;
    logic              sweep_rd;
    logic              scan_rd;
    logic [NODE_W-1:0] start_k;
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] child;
    logic              missing;
    logic              is_leaf;
    logic [NODE_W-1:0] root;

    // effective symbol count: zero acts as one, clamp at the memory limit
    always_comb
    begin
        if (symbol_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (symbol_count_reg > CNT_W'(MAX_SYMBOLS))
            n_eff = CNT_W'(MAX_SYMBOLS);
        else
            n_eff = symbol_count_reg;
    end

    always_comb
    begin
        shifted    = {32'd0, table_byte[6:0]} << shift_reg;
        acc_next   = acc_reg;
        shift_next = shift_reg;
        if (shift_reg < 6'd32)
        begin
            acc_next   = acc_reg | shifted[FREQ_W-1:0];
            shift_next = shift_reg + 6'd7;
        end
        is_end   = !table_byte[7];
        store    = loaded_reg < n_eff;
        lc_after = store ? loaded_reg + CNT_W'(1) : loaded_reg;
    end

    assign root     = nodes_reg - NODE_W'(1);
    assign cur      = (walk_reg < nodes_reg) ? walk_reg : root;
    assign child    = bit_reg ? rd_q.right : rd_q.left;
    assign missing  = child >= nodes_reg;
    assign is_leaf  = child < {1'b0, leaf_count_reg};
    assign sweep_rd = k_reg < {1'b0, eff_n_reg};
    assign scan_rd  = k_reg < total_reg;
    assign start_k  = greedy_reg ? NODE_W'(j_reg) + NODE_W'(1) : '0;

    // node memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = k_reg[NODE_AW-1:0];
        wr_en   = 1'b0;
        wr_addr = loaded_reg[NODE_AW-1:0];
        wr_data = '{freq: acc_next, valid: (acc_next != '0),
                    left: {1'b0, loaded_reg}, right: {1'b0, loaded_reg}};
        if (cmd.load && is_end && store)
            wr_en = 1'b1;
        if (cmd.sweep_step)
            rd_en = sweep_rd;
        if (cmd.scan_step)
            rd_en = scan_rd;
        if (cmd.walk_read)
        begin
            rd_en   = 1'b1;
            rd_addr = cur[NODE_AW-1:0];
        end
        if (cmd.mark && best_reg != NO_NODE)
        begin
            wr_en   = 1'b1;
            wr_addr = best_reg[NODE_AW-1:0];
            wr_data = '{freq: best_rec_reg.freq, valid: 1'b0,
                        left: best_rec_reg.left, right: best_rec_reg.right};
        end
        if (cmd.parent)
        begin
            wr_en   = 1'b1;
            wr_addr = total_reg[NODE_AW-1:0];
            wr_data = '{freq: sum_reg, valid: 1'b1, left: ch0_reg, right: best_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= CNT_W'(256);
            greedy_reg       <= 1'b0;
            acc_reg          <= '0;
            shift_reg        <= '0;
            loaded_reg       <= '0;
            freq_total_reg   <= '0;
            tree_ready_reg   <= 1'b0;
            nodes_reg        <= '0;
            walk_reg         <= '0;
            leaf_count_reg   <= '0;
            eff_n_reg        <= '0;
            total_reg        <= '0;
            iter_reg         <= '0;
            k_reg            <= '0;
            kq_reg           <= '0;
            p_reg            <= 1'b0;
            seeded_reg       <= 1'b0;
            minv_reg         <= '0;
            best_reg         <= NO_NODE;
            j_reg            <= 1'b0;
            ch0_reg          <= NO_NODE;
            sum_reg          <= '0;
            bit_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SYMBOL_COUNT: symbol_count_reg <= cfg_data;
                    REG_GREEDY_MODE:  greedy_reg       <= cfg_data[0];
                    default:          ;
                endcase
            end

            if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (cmd.load)
            begin
                tree_ready_reg <= 1'b0;
                if (!is_end)
                begin
                    acc_reg   <= acc_next;
                    shift_reg <= shift_next;
                end
                else
                begin
                    acc_reg   <= '0;
                    shift_reg <= '0;
                    if (stat.build_start)
                    begin
                        loaded_reg     <= '0;
                        eff_n_reg      <= n_eff;
                        total_reg      <= {1'b0, n_eff};
                        iter_reg       <= '0;
                        k_reg          <= '0;
                        p_reg          <= 1'b0;
                        freq_total_reg <= '0;
                        j_reg          <= 1'b0;
                        sum_reg        <= '0;
                    end
                    else
                        loaded_reg <= lc_after;
                end
            end

            if (cmd.sweep_step)
            begin
                p_reg <= sweep_rd;
                if (sweep_rd)
                    k_reg <= k_reg + NODE_W'(1);
                if (p_reg)
                    freq_total_reg <= freq_total_reg + rd_q.freq;
            end

            if (cmd.pick_init)
            begin
                k_reg      <= '0;
                p_reg      <= 1'b0;
                seeded_reg <= 1'b0;
                minv_reg   <= '1;
                best_reg   <= NO_NODE;
            end

            if (cmd.scan_step)
            begin
                p_reg  <= scan_rd;
                kq_reg <= k_reg;
                if (scan_rd)
                    k_reg <= k_reg + NODE_W'(1);
                if (p_reg && rd_q.valid)
                begin
                    // greedy search seeds with the first valid node it meets
                    if (greedy_reg && !seeded_reg)
                    begin
                        seeded_reg   <= 1'b1;
                        best_reg     <= kq_reg;
                        minv_reg     <= rd_q.freq;
                        best_rec_reg <= rd_q;
                    end
                    else if (kq_reg >= start_k && rd_q.freq < minv_reg)
                    begin
                        best_reg     <= kq_reg;
                        minv_reg     <= rd_q.freq;
                        best_rec_reg <= rd_q;
                    end
                end
            end

            if (cmd.mark)
            begin
                if (best_reg != NO_NODE)
                    sum_reg <= sum_reg + best_rec_reg.freq;
                if (!j_reg)
                    ch0_reg <= best_reg;
                j_reg <= !j_reg;
            end

            if (cmd.parent)
            begin
                total_reg <= total_reg + NODE_W'(1);
                iter_reg  <= iter_reg + CNT_W'(1);
                sum_reg   <= '0;
                j_reg     <= 1'b0;
            end

            if (cmd.walk_read)
                bit_reg <= code_bit;

            if (cmd.walk_eval)
                walk_reg <= (missing || is_leaf) ? root : child;

            if (cmd.finish)
            begin
                nodes_reg      <= total_reg;
                walk_reg       <= total_reg - NODE_W'(1);
                leaf_count_reg <= eff_n_reg;
                tree_ready_reg <= 1'b1;
            end

            if (cmd.emit)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= cmd.emit_code;
                out_symbol_reg <= (cmd.emit_code == ST_SYMBOL) ? child[8:0] : '0;
                out_count_reg  <= (cmd.emit_code == ST_BUILT) ? total_reg : '0;
            end
        end
    end

    always_comb
    begin
        stat.build_start = is_end && (lc_after >= n_eff);
        stat.tree_ready  = tree_ready_reg;
        stat.sweep_done  = !sweep_rd && !p_reg;
        stat.scan_done   = !scan_rd && !p_reg;
        stat.j_is_one    = j_reg;
        stat.build_stop  = (sum_reg >= freq_total_reg)
                        || ((iter_reg + CNT_W'(1)) >= eff_n_reg)
                        || ((total_reg + NODE_W'(1)) >= NODE_W'(NODE_DEPTH));
        stat.walk_result = missing || is_leaf;
        stat.walk_code   = missing ? ST_MISSING : ST_SYMBOL;
        stat.slot_free   = !out_valid_reg || out_ch.ready;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.symbol     = out_symbol_reg;
    assign out_ch.node_count = out_count_reg;

`ifndef NO_ASSERTIONS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= NODE_W'(NODE_DEPTH))
        else $error("node count beyond memory depth");
    a_built_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_code == ST_BUILT) |=> tree_ready_reg)
        else $error("tree not ready after build report");
    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg < CNT_W'(MAX_SYMBOLS))
        else $error("loaded count out of range");
`endif

endmodule

// ----- hw/rtl/htb_controller.sv -----
module htb_controller
    import htb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_kind,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_code = ST_SYMBOL;
        in_ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!in_kind)
                    begin
                        cmd.load = 1'b1;
                        if (stat.build_start)
                            state_next = S_SWEEP;
                    end
                    else if (stat.tree_ready)
                    begin
                        cmd.walk_read = 1'b1;
                        state_next    = S_WALK;
                    end
                    else
                        state_next = S_NOTREE;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_done)
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.pick_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_MARK;
            end
            S_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = stat.j_is_one ? S_PARENT : S_PICK;
            end
            S_PARENT:
            begin
                cmd.parent = 1'b1;
                state_next = stat.build_stop ? S_DONE : S_PICK;
            end
            S_DONE:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_code = ST_BUILT;
                    cmd.finish    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_NOTREE:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_code = ST_NO_TREE;
                    state_next    = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (!stat.walk_result)
                begin
                    cmd.walk_eval = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.slot_free)
                begin
                    cmd.walk_eval = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_code = stat.walk_code;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/huffman_table_build_decode.sv -----
// huffman tree loader, builder and bit decoder. input words carry either a
// frequency table byte (kind 0, 7-bit little-endian varint, bit 7 continues) or
// one code bit (kind 1). the table byte that completes the last frequency also
// starts the build. the build first sums the leaf frequencies, then for each
// parent runs two minimum searches over the node memory through the single
// registered read port (a setup step, reads of every node below total, a drain
// of the read pipe and a step to clear the chosen node's valid bit), and
// appends the parent; after the last parent the node count is reported through
// the output register once it is free. a code bit first reads the node record,
// then steps to the child and, at a leaf or a missing child, emits a symbol or a
// missing-child status. a code bit while no tree is ready gives status 3.
// results sit in an output register; a new word is taken only while the
// controller is idle.
module huffman_table_build_decode
    import htb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    htb_in_if.sink               in_ch,
    htb_out_if.source            out_ch
);

    // command and status between the sequencer and the node datapath
    cmd_t  cmd;
    stat_t stat;

    htb_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_kind  (in_ch.kind),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // node memory, varint assembly, search registers and output register
    htb_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .table_byte (in_ch.table_byte),
        .code_bit   (in_ch.code_bit),
        .cmd        (cmd),
        .stat       (stat),
        .out_ch     (out_ch)
    );

endmodule

// ----- bench/huffman_table_build_decode_test.sv -----
`timescale 1ns / 1ps

module huffman_table_build_decode_test;
    import htb_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_WORDS = 370;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 400;

    // one decoder result as the block reports it
    typedef struct {
        status_t     status;
        logic [8:0]  symbol;
        logic [10:0] node_count;
    } result_t;

    // one row of the directed table: either a register write or an input word,
    // optionally with the expected result typed in
    typedef struct {
        bit          is_cfg;
        reg_index_t  cfg_reg;
        int          cfg_value;
        bit          kind;
        logic [7:0]  tbyte;
        bit          cbit;
        bit          typed;
        status_t     status;
        logic [8:0]  symbol;
        logic [10:0] node_count;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    htb_in_if in_ch ();
    htb_out_if out_ch ();

    huffman_table_build_decode uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // shadow copy of the decoder: node memory, varint assembly, walk state
    // ------------------------------------------------------------------
    logic [31:0] sh_freq [NODE_DEPTH];
    bit          sh_valid [NODE_DEPTH];
    logic [10:0] sh_left [NODE_DEPTH];
    logic [10:0] sh_right [NODE_DEPTH];
    int unsigned sh_nodes;
    int unsigned sh_walk;
    logic [31:0] sh_acc;
    int unsigned sh_shift;
    int unsigned sh_loaded;
    logic [31:0] sh_total;
    bit          sh_ready;
    int unsigned sh_leaves;
    int unsigned sh_symbol_count;
    bit          sh_greedy;

    result_t pending_results[$];
    int fails = 0;
    int words_sent = 0;
    int cycles = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    // symbol count after clamping to the legal range
    function automatic int unsigned leaves_for_count();
        int unsigned n;
        n = sh_symbol_count;
        if (n == 0)
            n = 1;
        if (n > MAX_SYMBOLS)
            n = MAX_SYMBOLS;
        return n;
    endfunction

    // smallest valid node below total; greedy mode seeds with the first valid
    // node and starts the scan just past the child index
    function automatic logic [10:0] lightest_node(int unsigned total, int unsigned j);
        logic [10:0] best;
        logic [31:0] minv;
        int unsigned k;
        int unsigned start;
        int unsigned t;
        best = NO_NODE;
        minv = 32'hFFFF_FFFF;
        start = 0;
        if (sh_greedy)
        begin
            t = 0;
            while (t < total && !sh_valid[t])
                t++;
            if (t < total)
            begin
                best = t[10:0];
                minv = sh_freq[t];
            end
            start = j + 1;
        end
        for (k = start; k < total; k++)
        begin
            if (sh_valid[k] && sh_freq[k] < minv)
            begin
                minv = sh_freq[k];
                best = k[10:0];
            end
        end
        return best;
    endfunction

    function automatic void grow_tree(int unsigned n);
        int unsigned i;
        int unsigned j;
        int unsigned total;
        logic [31:0] sum;
        logic [10:0] ch [2];
        total = n;
        sh_total = '0;
        for (i = 0; i < n; i++)
        begin
            sh_valid[i] = sh_freq[i] != 0;
            sh_left[i] = i[10:0];
            sh_right[i] = i[10:0];
            sh_total += sh_freq[i];
        end
        for (i = 0; i < n && total < NODE_DEPTH; i++)
        begin
            sum = '0;
            for (j = 0; j < 2; j++)
            begin
                ch[j] = lightest_node(total, j);
                if (ch[j] != NO_NODE)
                begin
                    sh_valid[ch[j]] = 1'b0;
                    sum += sh_freq[ch[j]];
                end
            end
            sh_valid[total] = 1'b1;
            sh_freq[total] = sum;
            sh_left[total] = ch[0];
            sh_right[total] = ch[1];
            total++;
            if (sum >= sh_total)
                break;
        end
        sh_nodes = total;
        sh_leaves = n;
        sh_walk = total - 1;
        sh_ready = 1'b1;
    endfunction

    // advance the shadow by one accepted word; returns 1 when a result follows
    function automatic bit decode_word(bit kind, logic [7:0] b, bit cb, output result_t r);
        logic [63:0] part;
        int unsigned n;
        int unsigned root;
        int unsigned cur;
        logic [10:0] child;
        r.status = ST_SYMBOL;
        r.symbol = '0;
        r.node_count = '0;
        if (!kind)
        begin
            sh_ready = 1'b0;
            if (sh_shift < 32)
            begin
                part = {57'b0, b[6:0]} << sh_shift;
                sh_acc |= part[31:0];
                sh_shift += 7;
            end
            if (b[7])
                return 1'b0;
            n = leaves_for_count();
            if (sh_loaded < n)
            begin
                sh_freq[sh_loaded] = sh_acc;
                sh_loaded++;
            end
            sh_acc = '0;
            sh_shift = 0;
            if (sh_loaded < n)
                return 1'b0;
            sh_loaded = 0;
            grow_tree(n);
            r.status = ST_BUILT;
            r.node_count = sh_nodes[10:0];
            return 1'b1;
        end
        if (!sh_ready)
        begin
            r.status = ST_NO_TREE;
            return 1'b1;
        end
        root = sh_nodes - 1;
        cur = sh_walk < sh_nodes ? sh_walk : root;
        child = cb ? sh_right[cur] : sh_left[cur];
        if (child == NO_NODE || child >= sh_nodes)
        begin
            sh_walk = root;
            r.status = ST_MISSING;
            return 1'b1;
        end
        if (child < sh_leaves)
        begin
            sh_walk = root;
            r.symbol = child[8:0];
            return 1'b1;
        end
        sh_walk = child;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.kind = 1'b0;
        in_ch.table_byte = '0;
        in_ch.code_bit = 1'b0;
    end

    // offer one word, wait for acceptance, then book its expected result;
    // a typed expectation replaces the shadow's one but the shadow still steps
    task automatic send_word(bit kind, logic [7:0] b, bit cb, bit typed, result_t typed_r);
        result_t r;
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_ch.valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.table_byte <= b;
        in_ch.code_bit <= cb;
        forever
        begin
            @(posedge clk);
            if (in_ch.ready)
                break;
        end
        words_sent++;
        if (decode_word(kind, b, cb, r))
        begin
            if (typed)
                r = typed_r;
            pending_results.insert(pending_results.size(), r);
        end
    endtask

    task automatic send_plain(bit kind, logic [7:0] b, bit cb);
        result_t none;
        none.status = ST_SYMBOL;
        none.symbol = '0;
        none.node_count = '0;
        send_word(kind, b, cb, 1'b0, none);
    endtask

    // let every booked result arrive, then give a stray code bit time to finish
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, int value);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SYMBOL_COUNT)
            sh_symbol_count = value & 32'h3FF;
        else
            sh_greedy = value[0];
    endtask

    // one frequency: either raw random varint bytes or a small encoded value
    task automatic send_frequency();
        int nbytes;
        int v;
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0)
        begin
            nbytes = $urandom_range(1, 6);
            repeat (nbytes - 1)
            begin
                b = 8'($urandom_range(0, 255));
                send_plain(1'b0, b | 8'h80, 1'b0);
            end
            b = 8'($urandom_range(0, 255));
            send_plain(1'b0, b & 8'h7F, 1'b0);
        end
        else
        begin
            v = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 300);
            while (v > 127)
            begin
                send_plain(1'b0, 8'h80 | v[6:0], 1'b0);
                v = v >> 7;
            end
            send_plain(1'b0, v[7:0], 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    int hold_left = 0;
    int stall_left = 0;
    bit hold_done = 1'b0;

    initial
        out_ch.ready = 1'b0;

    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // compare each result word with the oldest booked one
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: status %0d", out_ch.status);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, out_ch.status);
                    fails++;
                end
                if (out_ch.symbol !== want.symbol)
                begin
                    $error("symbol: expected %0d, actual %0d", want.symbol, out_ch.symbol);
                    fails++;
                end
                if (out_ch.node_count !== want.node_count)
                begin
                    $error("node_count: expected %0d, actual %0d",
                           want.node_count, out_ch.node_count);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("huffman_table_build_decode: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    row_t rows[$];

    function automatic row_t blank_row();
        row_t r;
        r.is_cfg = 1'b0;
        r.cfg_reg = REG_SYMBOL_COUNT;
        r.cfg_value = 0;
        r.kind = 1'b0;
        r.tbyte = '0;
        r.cbit = 1'b0;
        r.typed = 1'b0;
        r.status = ST_SYMBOL;
        r.symbol = '0;
        r.node_count = '0;
        return r;
    endfunction

    function automatic row_t cfg_row(reg_index_t idx, int value);
        row_t r;
        r = blank_row();
        r.is_cfg = 1'b1;
        r.cfg_reg = idx;
        r.cfg_value = value;
        return r;
    endfunction

    function automatic row_t word_row(bit kind, logic [7:0] b, bit cb);
        row_t r;
        r = blank_row();
        r.kind = kind;
        r.tbyte = b;
        r.cbit = cb;
        return r;
    endfunction

    function automatic row_t typed_row(bit kind, logic [7:0] b, bit cb, status_t st,
                                       int sym, int cnt);
        row_t r;
        r = word_row(kind, b, cb);
        r.typed = 1'b1;
        r.status = st;
        r.symbol = sym[8:0];
        r.node_count = cnt[10:0];
        return r;
    endfunction

    function automatic void add_row(row_t r);
        rows.insert(rows.size(), r);
    endfunction

    initial
    begin
        result_t tr;
        int i;
        int n;
        int m;
        int bits;

        sh_nodes = 0;
        sh_walk = 0;
        sh_acc = '0;
        sh_shift = 0;
        sh_loaded = 0;
        sh_total = '0;
        sh_ready = 1'b0;
        sh_leaves = 0;
        sh_symbol_count = 256;
        sh_greedy = 1'b0;

        // code bit straight after reset: no tree yet
        add_row(typed_row(1'b1, 8'h00, 1'b0, ST_NO_TREE, 0, 0));
        // zero symbol count acts as one leaf
        add_row(cfg_row(REG_SYMBOL_COUNT, 0));
        add_row(cfg_row(REG_GREEDY_MODE, 0));
        add_row(word_row(1'b0, 8'h85, 1'b0));
        add_row(typed_row(1'b0, 8'h01, 1'b0, ST_BUILT, 0, 2));
        add_row(typed_row(1'b1, 8'h00, 1'b0, ST_SYMBOL, 0, 0));
        // lone leaf has no right sibling
        add_row(typed_row(1'b1, 8'h00, 1'b1, ST_MISSING, 0, 0));
        // overlong varint, payload past bit 31 dropped
        for (i = 0; i < 5; i++)
            add_row(word_row(1'b0, 8'hFF, 1'b0));
        add_row(word_row(1'b0, 8'h7F, 1'b0));
        add_row(word_row(1'b1, 8'h00, 1'b0));
        // table byte drops the tree at once
        add_row(word_row(1'b0, 8'h80, 1'b0));
        add_row(typed_row(1'b1, 8'h00, 1'b1, ST_NO_TREE, 0, 0));
        // zero frequency: root has no children
        add_row(word_row(1'b0, 8'h00, 1'b0));
        add_row(typed_row(1'b1, 8'h00, 1'b0, ST_MISSING, 0, 0));
        // small greedy tree
        add_row(cfg_row(REG_SYMBOL_COUNT, 3));
        add_row(cfg_row(REG_GREEDY_MODE, 1));
        add_row(word_row(1'b0, 8'h01, 1'b0));
        add_row(word_row(1'b0, 8'h01, 1'b0));
        add_row(word_row(1'b0, 8'h02, 1'b0));
        add_row(word_row(1'b1, 8'h00, 1'b0));
        add_row(word_row(1'b1, 8'h00, 1'b1));
        add_row(word_row(1'b1, 8'h00, 1'b1));
        add_row(word_row(1'b1, 8'h00, 1'b0));
        // count above the memory limit, then lowered mid-table: surplus frequency
        add_row(cfg_row(REG_SYMBOL_COUNT, 1023));
        add_row(word_row(1'b0, 8'h03, 1'b0));
        add_row(word_row(1'b0, 8'h05, 1'b0));
        add_row(word_row(1'b0, 8'h02, 1'b0));
        add_row(cfg_row(REG_SYMBOL_COUNT, 2));
        add_row(word_row(1'b0, 8'h07, 1'b0));
        add_row(word_row(1'b1, 8'h00, 1'b1));

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[k])
        begin
            if (rows[k].is_cfg)
                write_reg(rows[k].cfg_reg, rows[k].cfg_value);
            else
            begin
                tr.status = rows[k].status;
                tr.symbol = rows[k].symbol;
                tr.node_count = rows[k].node_count;
                send_word(rows[k].kind, rows[k].tbyte, rows[k].cbit, rows[k].typed, tr);
            end
        end

        // random phases: one table, then a run of code bits
        words_sent = 0;
        hold_req = 1'b1;
        while (words_sent < RANDOM_WORDS)
        begin
            if (words_sent > RANDOM_WORDS * 4 / 5)
                idle_on = 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
            write_reg(REG_SYMBOL_COUNT, n);
            write_reg(REG_GREEDY_MODE, $urandom_range(0, 1));
            // stray bits against whatever tree is standing
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    send_plain(1'b1, 8'h00, 1'($urandom_range(0, 1)));
            if (n > 1 && $urandom_range(0, 6) == 0)
            begin
                // count lowered mid-table: the next frequency is surplus
                m = $urandom_range(1, n - 1);
                repeat (m)
                    send_frequency();
                write_reg(REG_SYMBOL_COUNT, $urandom_range(1, m));
                send_frequency();
            end
            else
                repeat (n)
                    send_frequency();
            bits = $urandom_range(10, 30);
            repeat (bits)
                send_plain(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end

        drain();
        if (fails == 0)
            $display("huffman_table_build_decode: match");
        else
            $display("huffman_table_build_decode: mismatch");
        $finish;
    end

endmodule
